@@ rtl/sfb_pkg.sv @@
// Shared types and constants for the serial-bus slave frame buffer.
`default_nettype none

package sfb_pkg;

    localparam int FRAME_BYTES_DEF = 8;
    localparam int BYTE_W          = 8;
    localparam int SLOT_W          = 3;
    // Host-visible slots; the slot field reaches eight positions at most.
    localparam int HOST_SLOTS      = 1 << SLOT_W;

    typedef enum logic [1:0] {
        OP_BUS   = 2'd0,
        OP_WRITE = 2'd1,
        OP_READ  = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef struct packed {
        t_op               operation;
        logic [BYTE_W-1:0] rx_byte;
        logic              collision;
        logic [SLOT_W-1:0] slot;
        logic [BYTE_W-1:0] tx_data;
    } t_item;

    typedef struct packed {
        logic [BYTE_W-1:0] tx_byte;
        logic              frame_ready;
        logic [BYTE_W-1:0] read_data;
        logic              reply_done;
    } t_result;

endpackage

`default_nettype wire

@@ rtl/sfb_in_reg.sv @@
// Input register stage: holds one accepted item until the frame logic takes it.
`default_nettype none

module sfb_in_reg (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  wire sfb_pkg::t_item i_item,
    output logic                o_valid,
    input  wire logic           i_take,
    output sfb_pkg::t_item      o_item
);

    logic           r_valid;
    sfb_pkg::t_item r_item;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

endmodule

`default_nettype wire

@@ rtl/sfb_core.sv @@
// Frame state and per-item update: reply send, receive collection, host access.
`default_nettype none

module sfb_core #(
    parameter int FRAME_BYTES = sfb_pkg::FRAME_BYTES_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_fire,
    input  wire sfb_pkg::t_item i_item,
    output sfb_pkg::t_result    o_result
);

    // Only the host-reachable slots are stored; the rest read as zero.
    localparam int Slots  = (FRAME_BYTES < sfb_pkg::HOST_SLOTS) ?
                            FRAME_BYTES : sfb_pkg::HOST_SLOTS;
    localparam int IDX_W  = $clog2(Slots);
    localparam int POS_W  = $clog2(FRAME_BYTES);
    localparam int CNT_W  = $clog2(FRAME_BYTES + 1);
    localparam int BYTE_W = sfb_pkg::BYTE_W;

    logic [BYTE_W-1:0] r_rx_frame [Slots];
    logic [BYTE_W-1:0] n_rx_frame [Slots];
    logic [BYTE_W-1:0] r_reply    [Slots];
    logic [BYTE_W-1:0] n_reply    [Slots];
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic              r_flag;
    logic              n_flag;
    logic [POS_W-1:0]  r_pos;
    logic [POS_W-1:0]  n_pos;

    logic              flag_set;
    logic              slot_ok;

    always_comb begin
        n_rx_frame = r_rx_frame;
        n_reply    = r_reply;
        n_count    = r_count;
        n_flag     = r_flag;
        n_pos      = r_pos;
        flag_set   = 1'b0;
        slot_ok    = (32'(i_item.slot) < Slots);

        o_result.tx_byte    = '0;
        o_result.read_data  = '0;
        o_result.reply_done = 1'b0;

        case (i_item.operation)
            sfb_pkg::OP_BUS: begin
                if (r_reply[0] != '0) begin
                    if (32'(r_pos) < Slots) begin
                        o_result.tx_byte = r_reply[r_pos[IDX_W-1:0]];
                    end
                    if (!i_item.collision) begin
                        if (r_pos == POS_W'(FRAME_BYTES - 1)) begin
                            // last byte sent: disarm and restart receive
                            n_pos               = '0;
                            n_count             = '0;
                            n_reply[0]          = '0;
                            o_result.reply_done = 1'b1;
                        end else begin
                            n_pos = r_pos + 1'b1;
                        end
                    end
                end else begin
                    flag_set = r_flag || (i_item.rx_byte != '0);
                    n_flag   = flag_set;
                    if (flag_set && (r_count < CNT_W'(FRAME_BYTES))) begin
                        if (32'(r_count) < Slots) begin
                            n_rx_frame[r_count[IDX_W-1:0]] = i_item.rx_byte;
                        end
                        n_count = r_count + 1'b1;
                    end
                    if (n_count == CNT_W'(FRAME_BYTES)) begin
                        n_flag = 1'b0;
                    end
                end
            end
            sfb_pkg::OP_WRITE: begin
                if (slot_ok) begin
                    n_reply[i_item.slot[IDX_W-1:0]] = i_item.tx_data;
                end
            end
            sfb_pkg::OP_READ: begin
                if (slot_ok) begin
                    o_result.read_data = r_rx_frame[i_item.slot[IDX_W-1:0]];
                end
            end
            default: begin
            end
        endcase

        o_result.frame_ready = (n_reply[0] == '0) && (n_count == CNT_W'(FRAME_BYTES));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < Slots; k++) begin
                r_rx_frame[k] <= '0;
                r_reply[k]    <= '0;
            end
            r_count <= '0;
            r_flag  <= 1'b0;
            r_pos   <= '0;
        end else if (i_fire) begin
            r_rx_frame <= n_rx_frame;
            r_reply    <= n_reply;
            r_count    <= n_count;
            r_flag     <= n_flag;
            r_pos      <= n_pos;
        end
    end

endmodule

`default_nettype wire

@@ rtl/sfb_out_reg.sv @@
// Result register: holds one finished result until the receiver takes it.
`default_nettype none

module sfb_out_reg (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_load,
    input  wire sfb_pkg::t_result i_result,
    output logic                  o_can_load,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output sfb_pkg::t_result      o_result
);

    logic             r_valid;
    sfb_pkg::t_result r_result;

    assign o_can_load = !r_valid || i_ready;
    assign o_valid    = r_valid;
    assign o_result   = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_load) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && o_can_load) begin
            r_result <= i_result;
        end
    end

endmodule

`default_nettype wire

@@ rtl/spi_slave_frame_buffer_top.sv @@
// Slave-side serial bus frame buffer: top level with input and result channels.
//
// Input channel (i_in_valid / o_in_ready) carries one item: a bus byte
// exchange, a host write of a reply slot, or a host read of a receive slot.
// Output channel (o_out_valid / i_out_ready) returns exactly one result per
// item, in order.
// An accepted item enters the input register; its result is loaded into the
// result register once that register has room, and o_out_valid then rises.
// Throughput: one item per cycle while the receiver takes results; the
// combinational frame update between the two registers sets that figure.
// A new item is taken while a finished result waits, as long as the input
// register is free or moves on in the same cycle.
// When the receiver stalls, the result register holds, the input register
// fills, and o_in_ready drops until the receiver takes the result.
// Reset (i_rst_n low, synchronous) empties both registers, clears the
// receive and reply frames, the receive count, the receive flag and the
// reply position.
`default_nettype none

module spi_slave_frame_buffer_top #(
    parameter int FRAME_BYTES = sfb_pkg::FRAME_BYTES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [1:0]  i_operation,
    input  wire logic [7:0]  i_rx_byte,
    input  wire logic        i_collision,
    input  wire logic [2:0]  i_slot,
    input  wire logic [7:0]  i_tx_data,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [7:0]       o_tx_byte,
    output logic             o_frame_ready,
    output logic [7:0]       o_read_data,
    output logic             o_reply_done
);

    sfb_pkg::t_item   in_item;
    sfb_pkg::t_item   held_item;
    sfb_pkg::t_result core_result;
    sfb_pkg::t_result out_result;
    logic             held_valid;
    logic             can_load;
    logic             fire;

    assign in_item.operation = sfb_pkg::t_op'(i_operation);
    assign in_item.rx_byte   = i_rx_byte;
    assign in_item.collision = i_collision;
    assign in_item.slot      = i_slot;
    assign in_item.tx_data   = i_tx_data;

    // advance the held item whenever the result register has room
    assign fire = held_valid && can_load;

    sfb_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_item  (in_item),
        .o_valid (held_valid),
        .i_take  (can_load),
        .o_item  (held_item)
    );

    sfb_core #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (held_item),
        .o_result (core_result)
    );

    sfb_out_reg u_out_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (held_valid),
        .i_result   (core_result),
        .o_can_load (can_load),
        .o_valid    (o_out_valid),
        .i_ready    (i_out_ready),
        .o_result   (out_result)
    );

    assign o_tx_byte     = out_result.tx_byte;
    assign o_frame_ready = out_result.frame_ready;
    assign o_read_data   = out_result.read_data;
    assign o_reply_done  = out_result.reply_done;

endmodule

`default_nettype wire
